// ===== design/bsd_pkg.sv =====
// Shared types for the bubble sort core: the word type of one element and
// the result bundle of the compare-swap unit. No dependencies.
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // Result of one compare-swap step between the carried word and the next word.
  typedef struct packed {
    logic  swap;
    word_t wr_word;
    word_t keep_word;
  } cswap_t;

endpackage

// ===== design/bsd_cswap.sv =====
// Compare-swap unit of the bubble sort core: one signed comparison per step.
// Depends on bsd_pkg for the word and result types.
`timescale 1ns / 1ps

module bsd_cswap (
  input  logic           desc_i,
  input  bsd_pkg::word_t carry_i,
  input  bsd_pkg::word_t next_i,
  output bsd_pkg::cswap_t res_o
);

  logic swap;

  // Swap only on strict inequality, so equal words keep their order.
  assign swap = desc_i ? (next_i > carry_i) : (next_i < carry_i);

  always_comb begin
    res_o.swap      = swap;
    res_o.wr_word   = swap ? next_i : carry_i;
    res_o.keep_word = swap ? carry_i : next_i;
  end

endmodule

// ===== design/bubble_sort_with_direction_core.sv =====
// Top level of the bubble sort core: element store, pass sequencer and output register.
// Depends on bsd_pkg and bsd_cswap.
//
// Channel   Dir  Handshake                    Contents
// cfg       in   cfg_valid_i / cfg_ready_o    cfg_data_i: descending
// s_axis    in   s_axis_tvalid / tready       tdata: element_value; tlast: is_last
// m_axis    out  m_axis_tvalid / tready       tdata: sorted_value; tlast: last_out;
//                                             tuser: overflowed
//
// A set of n elements loads one word per cycle, then sorts in n-1 passes, each
// streaming the store once through the single compare-swap unit with one memory
// read and one memory write per cycle. Each result then goes through a memory
// read and an output register load, and waits while m_axis_tready is low.
// The input is not ready while a set sorts or drains.
// Reset clears the count, the overflow flag, the direction and the output valid.
`timescale 1ns / 1ps

module bubble_sort_with_direction_core #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] element_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // [0] overflowed
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FIRST,
    ST_RUN,
    ST_TAIL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  pass_q, pass_d;
  logic           ovf_q, ovf_d;
  logic           desc_q, desc_d;
  bsd_pkg::word_t carry_q, carry_d;
  logic           out_vld_q, out_vld_d;
  bsd_pkg::word_t out_data_q, out_data_d;
  logic           out_last_q, out_last_d;
  logic           out_ovf_q, out_ovf_d;

  bsd_pkg::word_t mem [MAX_ELEMENTS];
  bsd_pkg::word_t rd_data_q;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           wr_en;
  bsd_pkg::word_t wr_data;

  logic [CW-1:0]  idx_inc;
  logic [CW-1:0]  cnt_inc;
  logic           idx_at_end;
  logic           not_full;
  bsd_pkg::cswap_t cs;

  bsd_cswap u_cswap (
    .desc_i  (desc_q),
    .carry_i (carry_q),
    .next_i  (rd_data_q),
    .res_o   (cs)
  );

  assign idx_inc    = idx_q + CW'(1);
  assign cnt_inc    = cnt_q + CW'(1);
  assign idx_at_end = (idx_q == cnt_q - CW'(1));
  assign not_full   = (cnt_q < CW'(MAX_ELEMENTS));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    ovf_d      = ovf_q;
    desc_d     = cfg_valid_i ? cfg_data_i : desc_q;
    carry_d    = carry_q;
    out_vld_d  = (out_vld_q && m_axis_tready) ? 1'b0 : out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    rd_addr    = idx_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cnt_q[AW-1:0];
    wr_data    = bsd_pkg::word_t'(s_axis_tdata);

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (not_full) begin
            wr_en = 1'b1;
            cnt_d = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            idx_d  = '0;
            pass_d = '0;
            // A single held element needs no sorting.
            if ((not_full ? cnt_inc : cnt_q) < CW'(2)) begin
              state_d = ST_EMIT_RD;
            end else begin
              state_d = ST_LOAD;
            end
          end
        end
      end
      ST_LOAD: begin
        rd_addr = '0;
        state_d = ST_FIRST;
      end
      ST_FIRST: begin
        carry_d = rd_data_q;
        rd_addr = AW'(1);
        idx_d   = CW'(1);
        state_d = ST_RUN;
      end
      ST_RUN: begin
        // The carried word bubbles forward; the loser of each compare is written back.
        wr_en   = 1'b1;
        wr_addr = AW'(idx_q - CW'(1));
        wr_data = cs.wr_word;
        carry_d = cs.keep_word;
        if (idx_at_end) begin
          state_d = ST_TAIL;
        end else begin
          rd_addr = idx_inc[AW-1:0];
          idx_d   = idx_inc;
        end
      end
      ST_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0];
        wr_data = carry_q;
        idx_d   = '0;
        if (pass_q == cnt_q - CW'(2)) begin
          pass_d  = '0;
          state_d = ST_EMIT_RD;
        end else begin
          pass_d  = pass_q + CW'(1);
          state_d = ST_LOAD;
        end
      end
      ST_EMIT_RD: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_vld_d  = 1'b1;
        out_data_d = rd_data_q;
        out_last_d = idx_at_end;
        out_ovf_d  = ovf_q;
        if (idx_at_end) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      pass_q     <= '0;
      ovf_q      <= 1'b0;
      desc_q     <= 1'b0;
      carry_q    <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      pass_q     <= pass_d;
      ovf_q      <= ovf_d;
      desc_q     <= desc_d;
      carry_q    <= carry_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = 32'(out_data_q);
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_ovf_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ELEMENTS))
    else $error("element count exceeds capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CW'(MAX_ELEMENTS)))
    else $error("overflow flag set with room left in the store");

  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD || state_q == ST_EMIT_LD) |-> !wr_en)
    else $error("store written while results drain");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_LD) |-> !out_vld_q)
    else $error("output word overwritten before it was taken");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_TAIL) |-> (pass_q < cnt_q && idx_q < cnt_q))
    else $error("sort sequencer ran past the held elements");
`endif

endmodule

// ===== tb/sv/tb_bubble_sort_with_direction_core.sv =====
// Self-checking bench for bubble_sort_with_direction_core: streams sets of signed words,
// sorts a private copy of each set and compares every output word field by field.
// Depends on bsd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_bubble_sort_with_direction_core;

  localparam int unsigned MAX_ELEMENTS  = 64;
  localparam logic        DIR_ASCENDING  = 1'b0;
  localparam logic        DIR_DESCENDING = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam longint      WATCHDOG_NS   = 3_000_000;

  typedef struct packed {
    bsd_pkg::word_t value;
    logic           last;
    logic           ovf;
  } sorted_word_t;

  typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    bsd_pkg::word_t value;
    logic           last;
    logic           typed;
    sorted_word_t   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] element_value
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] sorted_value
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;        // [0] overflowed

  // Typed expectation that travels alongside the word on the input bus.
  logic         row_typed = 1'b0;
  sorted_word_t row_want = '0;

  // Private copy of the core state.
  bsd_pkg::word_t held_words [MAX_ELEMENTS];
  int unsigned  held_count = 0;
  logic         dropped_any = 1'b0;
  logic         desc_mode = DIR_ASCENDING;
  sorted_word_t expected_words [$];

  plan_row_t    plan_q [$];
  int unsigned  burst_left = 0;
  int unsigned  fail_count = 0;
  int unsigned  sets_done = 0;
  int unsigned  descending_sets = 0;
  int unsigned  overflow_sets = 0;
  int unsigned  words_in = 0;
  int unsigned  words_out = 0;
  int unsigned  cfg_writes = 0;

  bubble_sort_with_direction_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stores one accepted word; a word flagged last closes the set, which is then
  // bubble-sorted and queued as the expected output words.
  function automatic void collect_and_sort(input bsd_pkg::word_t v, input logic last,
                                           input logic typed, input sorted_word_t want);
    sorted_word_t   w;
    bsd_pkg::word_t tmp;
    int unsigned    n;
    int unsigned    p;
    int unsigned    i;
    logic           do_swap;
    words_in++;
    if (held_count < MAX_ELEMENTS) begin
      held_words[held_count] = v;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!last) return;
    n = held_count;
    for (p = 0; p + 1 < n; p++) begin
      for (i = 0; i + 1 < n; i++) begin
        // Strict comparison only, so equal words never trade places.
        do_swap = desc_mode ? (held_words[i+1] > held_words[i]) :
                              (held_words[i+1] < held_words[i]);
        if (do_swap) begin
          tmp             = held_words[i];
          held_words[i]   = held_words[i+1];
          held_words[i+1] = tmp;
        end
      end
    end
    if (typed) begin
      expected_words.push_back(want);
    end else begin
      for (i = 0; i < n; i++) begin
        w.value = held_words[i];
        w.last  = (i + 1 == n);
        w.ovf   = dropped_any;
        expected_words.push_back(w);
      end
    end
    sets_done++;
    if (desc_mode == DIR_DESCENDING) descending_sets++;
    if (dropped_any) overflow_sets++;
    held_count  = 0;
    dropped_any = 1'b0;
  endfunction

  // All handshakes are observed here, on values sampled at the clock edge.
  always @(posedge clk_i) begin
    sorted_word_t w;
    if (cfg_valid_i && cfg_ready_o) begin
      desc_mode = cfg_data_i;
      cfg_writes++;
    end
    if (s_axis_tvalid && s_axis_tready)
      collect_and_sort(s_axis_tdata, s_axis_tlast, row_typed, row_want);
    if (m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (expected_words.size() == 0) begin
        $error("unexpected output word: sorted_value %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tdata !== w.value) begin
          $error("sorted_value mismatch: expected %0d, actual %0d", w.value,
                 $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last_out mismatch: expected %0b, actual %0b", w.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[0] !== w.ovf) begin
          $error("overflowed mismatch: expected %0b, actual %0b", w.ovf, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Output side: random ready runs and stalls, plus long hold-offs that back the
  // core up while the input side keeps offering words.
  initial begin
    int unsigned words_taken;
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned next_hold;
    logic        stalled;
    words_taken = 0;
    hold_left   = 0;
    run_left    = 0;
    next_hold   = 100;
    stalled     = 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) words_taken++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (words_taken >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 80;
        m_axis_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalled  = !stalled;
          run_left = stalled ? $urandom_range(1, 6) :
                     (($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) :
                                                     $urandom_range(1, 15));
        end
        run_left--;
        m_axis_tready <= !stalled;
      end
    end
  end

  function automatic void plan_row(input row_kind_e kind, input bsd_pkg::word_t v,
                                   input logic last, input logic typed);
    plan_row_t row;
    row            = '0;
    row.kind       = kind;
    row.value      = v;
    row.last       = last;
    row.typed      = typed;
    row.want.value = v;
    row.want.last  = 1'b1;
    row.want.ovf   = 1'b0;
    plan_q.push_back(row);
  endfunction

  function automatic bsd_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0: return bsd_pkg::word_t'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return bsd_pkg::word_t'($urandom);
    endcase
  endfunction

  // Offers one word; the sender works in bursts with idle gaps in between.
  task automatic send_elem(input bsd_pkg::word_t v, input logic last, input logic typed,
                           input sorted_word_t want);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    row_typed     <= typed;
    row_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  // Stops offering and waits until every expected word has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_direction(input logic dir);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= dir;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    plan_row_t   row;
    int unsigned r;
    int unsigned k;
    int unsigned set_len;
    int unsigned set_idx;
    int unsigned random_sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Single-word sets carry their expected word in the table.
    plan_row(ROW_CFG,  {31'b0, DIR_ASCENDING}, 1'b0, 1'b0);
    plan_row(ROW_ELEM, 32'h7FFF_FFFF, 1'b1, 1'b1);
    plan_row(ROW_ELEM, 32'h8000_0000, 1'b1, 1'b1);
    plan_row(ROW_ELEM, 32'h0000_0000, 1'b1, 1'b1);
    plan_row(ROW_ELEM, 32'hFFFF_FFFF, 1'b1, 1'b1);
    plan_row(ROW_ELEM, 5,             1'b0, 1'b0);
    plan_row(ROW_ELEM, -3,            1'b0, 1'b0);
    plan_row(ROW_ELEM, 32'h7FFF_FFFF, 1'b0, 1'b0);
    plan_row(ROW_ELEM, 32'h8000_0000, 1'b0, 1'b0);
    plan_row(ROW_ELEM, 5,             1'b1, 1'b0);
    plan_row(ROW_ELEM, 7,             1'b0, 1'b0);
    plan_row(ROW_ELEM, 7,             1'b1, 1'b0);
    plan_row(ROW_CFG,  {31'b0, DIR_DESCENDING}, 1'b0, 1'b0);
    plan_row(ROW_ELEM, 1,             1'b1, 1'b1);
    plan_row(ROW_ELEM, 32'h8000_0000, 1'b0, 1'b0);
    plan_row(ROW_ELEM, -1,            1'b0, 1'b0);
    plan_row(ROW_ELEM, 32'h7FFF_FFFF, 1'b0, 1'b0);
    plan_row(ROW_ELEM, 0,             1'b0, 1'b0);
    plan_row(ROW_ELEM, -1,            1'b1, 1'b0);
    plan_row(ROW_ELEM, 1,             1'b0, 1'b0);
    plan_row(ROW_ELEM, 2,             1'b0, 1'b0);
    plan_row(ROW_ELEM, 3,             1'b1, 1'b0);
    plan_row(ROW_CFG,  {31'b0, DIR_ASCENDING}, 1'b0, 1'b0);

    for (r = 0; r < plan_q.size(); r++) begin
      row = plan_q[r];
      if (row.kind == ROW_CFG) write_direction(row.value[0]);
      else send_elem(row.value, row.last, row.typed, row.want);
    end

    // Random part: a completely full set, a set that overruns the store (its
    // closing word is dropped too), then mostly short sets of random words.
    // The set after the overrun is offered at once, so it waits through the
    // first long hold-off on the output side.
    random_sent = 0;
    set_idx     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (set_idx == 0) begin
        write_direction(DIR_DESCENDING);
        set_len = MAX_ELEMENTS;
      end else if (set_idx == 1) begin
        write_direction(DIR_ASCENDING);
        set_len = MAX_ELEMENTS + $urandom_range(1, 4);
      end else begin
        if (set_idx > 2 && $urandom_range(0, 3) == 0) write_direction($urandom_range(0, 1) == 1);
        set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      end
      for (k = 1; k <= set_len; k++) send_elem(rand_word(), k == set_len, 1'b0, '0);
      random_sent += set_len;
      set_idx++;
    end

    wait_drained();
    $display("Run covered %0d sets (%0d descending, %0d with dropped words) and %0d cfg writes.",
             sets_done, descending_sets, overflow_sets, cfg_writes);
    $display("%0d words went in and %0d sorted words came out.", words_in, words_out);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
design/bsd_pkg.sv
design/bsd_cswap.sv
design/bubble_sort_with_direction_core.sv
tb/sv/tb_bubble_sort_with_direction_core.sv
